### rtl/fhdc_pkg.sv
// Shared types and constants for the frame hash desync checker.
// No dependencies; used by the top level.
`default_nettype none

package fhdc_pkg;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_CMP
   } fhdc_state_type;

   // One ring entry: frame tag above, hash below
   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] hash;
   } ring_entry_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] agreed_frames;
      logic [31:0] first_bad_frame;
      logic        desync_flag;
      logic [31:0] counterpart_hash;
      logic        new_desync;
      logic        send_sync;
   } rsp_data_type;

   localparam logic        REQ_LOCAL  = 1'b0;
   localparam logic        REQ_REMOTE = 1'b1;

   localparam int          CSR_ADDR_W         = 3;
   localparam logic        REG_SYNC_INTERVAL  = 1'b0;
   localparam logic [15:0] SYNC_INTERVAL_INIT = 16'd30;

   localparam logic [31:0] TAG_INIT   = 32'hFFFF_FFFF;
   localparam logic [31:0] HASH_INIT  = 32'h0000_0000;
   localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

### rtl/fhdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fhdc_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fhdc_rem.sv
// Iterative remainder unit: 32-bit dividend, one quotient bit per cycle.
// No dependencies; instanced once in the top level.
`default_nettype none

module fhdc_rem #(
   parameter int DIV_W = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [31:0]      dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic                  done,
   output logic      [DIV_W-1:0] remainder
);

   logic [31:0]      dq_ff, dq_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, dq_ff[31]};
      diff  = trial - {1'b0, divisor};
      fits  = trial >= {1'b0, divisor};
   end

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract where it fits
         dq_in  = {dq_ff[30:0], 1'b0};
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/frame_hash_desync_checker_top.sv
// Frame hash desync checker: two tagged hash rings in RAM, compare and stats.
// Depends on fhdc_pkg, fhdc_ram and fhdc_rem.
//
//   channel | direction | transfer carries
//   req     | in        | one local or peer frame/hash report
//   rsp     | out       | one result per report: sync request, desync state, counters
//   csr     | in/out    | APB-style access to sync_interval
//
// A report is accepted in IDLE, then passes the bit-serial frame mod sync_interval unit
// (32 steps, then done), a RAM read state and a compare state; the result shows on rsp
// the cycle after compare. The next report is not accepted until compare is through. The
// ring slot is the low bits of the frame, so RING_DEPTH must be a power of two; the block
// does not check it. After reset a clearing pass writes every ring slot with req_tready
// low. The result register lets the next report be accepted while a result waits; the
// compare stage holds while that register is full and rsp_tready is low.
`default_nettype none

module frame_hash_desync_checker_top #(
   parameter int RING_DEPTH = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [63:0]                       req_tdata,  // frame, hash
   input  wire logic                              req_tuser,  // req_type
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // send_sync, new_desync, counterpart_hash, desync_flag, first_bad_frame,
   // agreed_frames, zero pad
   output logic [103:0]                           rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [fhdc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic      [31:0]                       csr_prdata,
   output logic                                   csr_pready
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

   fhdc_pkg::fhdc_state_type state_ff, state_in;

   logic [15:0]         sync_interval_ff;
   logic [SLOT_W-1:0]   clr_cnt_ff;
   logic                remote_ff;
   logic [31:0]         frame_ff;
   logic [31:0]         hash_ff;
   logic                seen_ff, seen_in;
   logic [31:0]         bad_frame_ff, bad_frame_in;
   logic [31:0]         count_ff, count_in;
   logic                rsp_valid_ff;
   fhdc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_free;
   logic                start_div;
   logic                sync_done;
   logic [15:0]         sync_rem;
   logic [SLOT_W-1:0]   slot;
   logic                csr_write;

   logic                loc_we, rem_we, loc_re, rem_re;
   logic [SLOT_W-1:0]   wr_addr;
   fhdc_pkg::ring_entry_type wr_entry, loc_rd, rem_rd, other;
   logic                tag_hit, raised, announce, load_rsp;

   // ---------------- configuration ----------------
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == fhdc_pkg::REG_SYNC_INTERVAL) ?
                       {16'd0, sync_interval_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_interval_ff <= fhdc_pkg::SYNC_INTERVAL_INIT;
      end else if (csr_write && csr_paddr[2] == fhdc_pkg::REG_SYNC_INTERVAL) begin
         sync_interval_ff <= csr_pwdata[15:0];
      end
   end

   // ---------------- remainder unit ----------------
   assign accept    = req_tvalid && req_tready;
   assign start_div = accept;

   fhdc_rem #(.DIV_W(16)) u_sync_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (start_div),
      .dividend  (req_tdata[31:0]),
      .divisor   (sync_interval_ff),
      .done      (sync_done),
      .remainder (sync_rem)
   );

   // slot is frame mod ring depth: keep the low bits
   assign slot = frame_ff[SLOT_W-1:0];

   // ---------------- ring memories ----------------
   always_comb begin
      loc_we   = 1'b0;
      rem_we   = 1'b0;
      loc_re   = 1'b0;
      rem_re   = 1'b0;
      wr_addr  = slot;
      wr_entry = '{tag: frame_ff, hash: hash_ff};
      if (state_ff == fhdc_pkg::ST_CLEAR) begin
         loc_we   = 1'b1;
         rem_we   = 1'b1;
         wr_addr  = clr_cnt_ff;
         wr_entry = '{tag: fhdc_pkg::TAG_INIT, hash: fhdc_pkg::HASH_INIT};
      end else if (state_ff == fhdc_pkg::ST_READ) begin
         // write own ring, read the other ring at the same slot
         loc_we = (remote_ff == fhdc_pkg::REQ_LOCAL);
         rem_we = (remote_ff == fhdc_pkg::REQ_REMOTE);
         loc_re = (remote_ff == fhdc_pkg::REQ_REMOTE);
         rem_re = (remote_ff == fhdc_pkg::REQ_LOCAL);
      end
   end

   fhdc_ram #(.WIDTH($bits(fhdc_pkg::ring_entry_type)), .DEPTH(RING_DEPTH)) u_local_ring (
      .clock   (clock),
      .wr_en   (loc_we),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (loc_re),
      .rd_addr (slot),
      .rd_data (loc_rd)
   );

   fhdc_ram #(.WIDTH($bits(fhdc_pkg::ring_entry_type)), .DEPTH(RING_DEPTH)) u_remote_ring (
      .clock   (clock),
      .wr_en   (rem_we),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rem_re),
      .rd_addr (slot),
      .rd_data (rem_rd)
   );

   // ---------------- control ----------------
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fhdc_pkg::ST_CLEAR: if (clr_cnt_ff == LAST_SLOT) state_in = fhdc_pkg::ST_IDLE;
         fhdc_pkg::ST_IDLE:  if (req_tvalid) state_in = fhdc_pkg::ST_DIV;
         fhdc_pkg::ST_DIV:   if (sync_done) state_in = fhdc_pkg::ST_READ;
         fhdc_pkg::ST_READ:  state_in = fhdc_pkg::ST_CMP;
         fhdc_pkg::ST_CMP:   if (out_free) state_in = fhdc_pkg::ST_IDLE;
         default:            state_in = fhdc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         fhdc_pkg::ST_IDLE: req_tready = 1'b1;
         fhdc_pkg::ST_CMP:  load_rsp   = out_free;
         default: begin
            req_tready = 1'b0;
            load_rsp   = 1'b0;
         end
      endcase
   end

   // ---------------- compare and statistics ----------------
   always_comb begin
      other    = (remote_ff == fhdc_pkg::REQ_REMOTE) ? loc_rd : rem_rd;
      tag_hit  = (other.tag == frame_ff);
      seen_in      = seen_ff;
      bad_frame_in = bad_frame_ff;
      count_in     = count_ff;
      raised       = 1'b0;
      if (tag_hit) begin
         if (other.hash != hash_ff) begin
            if (!seen_ff) begin
               seen_in      = 1'b1;
               bad_frame_in = frame_ff;
               raised       = 1'b1;
            end
         end else if (count_ff != fhdc_pkg::COUNT_MAX) begin
            count_in = count_ff + 32'd1;
         end
      end
      announce = (remote_ff == fhdc_pkg::REQ_LOCAL) && (sync_interval_ff != 16'd0) &&
                 (sync_rem == 16'd0);
      rsp_data_in = '{pad: 5'd0, agreed_frames: count_in, first_bad_frame: bad_frame_in,
                      desync_flag: seen_in, counterpart_hash: other.hash,
                      new_desync: raised, send_sync: announce};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         remote_ff <= req_tuser;
         frame_ff  <= req_tdata[31:0];
         hash_ff   <= req_tdata[63:32];
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (reset) begin
         state_ff     <= fhdc_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         seen_ff      <= 1'b0;
         bad_frame_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fhdc_pkg::ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
         end
         if (load_rsp) begin
            seen_ff      <= seen_in;
            bad_frame_ff <= bad_frame_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff |=> seen_ff)
      else $error("desync flag dropped");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> (count_ff >= $past(count_ff)))
      else $error("agreement counter decreased");

   a_rsp_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == fhdc_pkg::ST_CMP)
      else $error("result loaded outside compare stage");

   a_one_ring_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fhdc_pkg::ST_CLEAR) |-> !(loc_we && rem_we))
      else $error("both rings written by one report");

   a_raise_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.new_desync) |-> (rsp_data_ff.desync_flag && seen_ff))
      else $error("new desync without sticky flag");
`endif

endmodule

`default_nettype wire
